// ----- rtl/slss_pkg.sv -----
// ----------------------------------------------------------------------------
// slss_pkg: shared types and constants of the skip-list sorted set
// Opcodes, status codes, sequencer states, the result record and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package slss_pkg;

    localparam int DEF_MAX_LEVEL = 15;
    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_KEY_WIDTH = 32;

    localparam int KEY_IN_W = 32;
    localparam int COUNT_W  = 11;
    localparam int THRESH_W = 8;

    localparam logic [31:0]         LFSR_SEED    = 32'hACE1ACE1;
    localparam logic [31:0]         LFSR_TAPS    = 32'h80200003;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd128;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_SEARCH     = 2'd1,
        OP_REMOVE     = 2'd2,
        OP_SEARCH_ALT = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FOUND    = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LINK,
        S_LINK_W,
        S_KEY_W,
        S_DECIDE,
        S_DRAW,
        S_POP,
        S_POP_W,
        S_INS_A,
        S_INS_B,
        S_RM_CHK,
        S_RM_WR,
        S_RM_PUSH,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t            status;
        logic               found;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/slss_ram.sv -----
// ----------------------------------------------------------------------------
// slss_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/slss_core.sv -----
// ----------------------------------------------------------------------------
// slss_core: skip-list walk and splice sequencer
// Walks the levels through the link and key memories with one comparator,
// then draws a level, pops or pushes the free stack and rewrites links.
// ----------------------------------------------------------------------------
`default_nettype none

module slss_core #(
    parameter int MAX_LEVEL = slss_pkg::DEF_MAX_LEVEL,
    parameter int CAPACITY  = slss_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = slss_pkg::DEF_KEY_WIDTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         in_op,
    input  wire logic [slss_pkg::KEY_IN_W-1:0]      in_key,
    input  wire logic [slss_pkg::THRESH_W-1:0]      thresh,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output slss_pkg::result_t                       res
);

    localparam int LEVELS = MAX_LEVEL + 1;
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int CAP_W  = $clog2(CAPACITY);
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int LINK_DEPTH = CAPACITY * (2 ** LVL_W);
    localparam logic [PTR_W-1:0] NIL     = PTR_W'(CAPACITY);
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(MAX_LEVEL);

    slss_pkg::state_t state_reg, state_next;

    logic [KEY_WIDTH-1:0] key_reg, key_in;
    slss_pkg::opcode_t    op_reg;
    logic [LVL_W-1:0]     lvl_reg, top_reg;
    logic [PTR_W-1:0]     cur_reg, nx_reg, hit_reg;
    logic                 cur_head_reg, present_reg;
    logic [CAP_W-1:0]     node_reg;
    logic [PTR_W-1:0]     free_cnt_reg, wm_reg;
    logic                 use_init_reg;
    logic [31:0]          lfsr_reg, lfsr_next;
    slss_pkg::status_t    status_reg;

    logic [PTR_W-1:0] head_reg [LEVELS];
    logic [PTR_W-1:0] pred_reg [LEVELS];
    logic             pred_head_reg [LEVELS];
    logic [PTR_W-1:0] succ_reg [LEVELS];

    // Memory ports
    logic                          link_we;
    logic [$clog2(LINK_DEPTH)-1:0] link_waddr, link_raddr;
    logic [PTR_W-1:0]              link_wdata, link_rdata;
    logic                          key_we;
    logic [CAP_W-1:0]              key_waddr, key_raddr;
    logic [KEY_WIDTH-1:0]          key_rdata;
    logic                          free_we;
    logic [CAP_W-1:0]              free_waddr, free_raddr;
    logic [CAP_W-1:0]              free_rdata;

    logic [PTR_W-1:0] nx_link, end_nx;
    logic             key_less, key_eq, lvl_end, end_eq;
    logic             draw_stop;
    logic [CAP_W-1:0] pop_pos, node_w;

    generate
        if (KEY_WIDTH <= slss_pkg::KEY_IN_W) begin : g_key_narrow
            assign key_in = in_key[KEY_WIDTH-1:0];
        end else begin : g_key_wide
            assign key_in = {{(KEY_WIDTH - slss_pkg::KEY_IN_W){in_key[slss_pkg::KEY_IN_W-1]}},
                             in_key};
        end
    endgenerate

    slss_ram #(.WIDTH(PTR_W), .DEPTH(LINK_DEPTH)) u_links (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );

    slss_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_keys (
        .aclk(aclk), .we(key_we), .waddr(key_waddr), .wdata(key_reg),
        .raddr(key_raddr), .rdata(key_rdata)
    );

    slss_ram #(.WIDTH(CAP_W), .DEPTH(CAPACITY)) u_free (
        .aclk(aclk), .we(free_we), .waddr(free_waddr), .wdata(hit_reg[CAP_W-1:0]),
        .raddr(free_raddr), .rdata(free_rdata)
    );

    always_comb begin
        nx_link   = cur_head_reg ? head_reg[lvl_reg] : link_rdata;
        key_less  = $signed(key_rdata) < $signed(key_reg);
        key_eq    = key_rdata == key_reg;
        lvl_end   = ((state_reg == slss_pkg::S_LINK_W) && (nx_link == NIL)) ||
                    ((state_reg == slss_pkg::S_KEY_W) && !key_less);
        end_nx    = (state_reg == slss_pkg::S_LINK_W) ? nx_link : nx_reg;
        end_eq    = (state_reg == slss_pkg::S_KEY_W) && key_eq;
        lfsr_next = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? slss_pkg::LFSR_TAPS : 32'd0);
        draw_stop = (lfsr_next[7:0] >= thresh) || (lvl_reg == LVL_TOP);
        pop_pos   = CAP_W'(free_cnt_reg - PTR_W'(1));
        // Stack slots below the low-water mark were never written since reset.
        node_w    = use_init_reg ? (CAP_W'(CAPACITY - 1) - free_cnt_reg[CAP_W-1:0])
                                 : free_rdata;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            slss_pkg::S_IDLE:    if (in_valid) state_next = slss_pkg::S_RD_LINK;
            slss_pkg::S_RD_LINK: state_next = slss_pkg::S_LINK_W;
            slss_pkg::S_LINK_W, slss_pkg::S_KEY_W: begin
                if (lvl_end) begin
                    state_next = (lvl_reg == '0) ? slss_pkg::S_DECIDE : slss_pkg::S_RD_LINK;
                end else if (state_reg == slss_pkg::S_LINK_W) begin
                    state_next = slss_pkg::S_KEY_W;
                end else begin
                    state_next = slss_pkg::S_RD_LINK;
                end
            end
            slss_pkg::S_DECIDE: begin
                priority case (op_reg)
                    slss_pkg::OP_INSERT:
                        state_next = (present_reg || free_cnt_reg == '0) ? slss_pkg::S_DONE
                                                                        : slss_pkg::S_DRAW;
                    slss_pkg::OP_REMOVE:
                        state_next = present_reg ? slss_pkg::S_RM_CHK : slss_pkg::S_DONE;
                    default: state_next = slss_pkg::S_DONE;
                endcase
            end
            slss_pkg::S_DRAW:    if (draw_stop) state_next = slss_pkg::S_POP;
            slss_pkg::S_POP:     state_next = slss_pkg::S_POP_W;
            slss_pkg::S_POP_W:   state_next = slss_pkg::S_INS_A;
            slss_pkg::S_INS_A:   state_next = slss_pkg::S_INS_B;
            slss_pkg::S_INS_B:
                state_next = (lvl_reg == top_reg) ? slss_pkg::S_DONE : slss_pkg::S_INS_A;
            slss_pkg::S_RM_CHK:
                state_next = (succ_reg[lvl_reg] != hit_reg) ? slss_pkg::S_RM_PUSH
                                                            : slss_pkg::S_RM_WR;
            slss_pkg::S_RM_WR:
                state_next = (lvl_reg == LVL_TOP) ? slss_pkg::S_RM_PUSH : slss_pkg::S_RM_CHK;
            slss_pkg::S_RM_PUSH: state_next = slss_pkg::S_DONE;
            slss_pkg::S_DONE:    if (res_ready) state_next = slss_pkg::S_IDLE;
            default:             state_next = slss_pkg::S_IDLE;
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        in_ready   = state_reg == slss_pkg::S_IDLE;
        res_valid  = state_reg == slss_pkg::S_DONE;
        res.status = status_reg;
        res.found  = present_reg;
        res.count  = slss_pkg::COUNT_W'(PTR_W'(CAPACITY) - free_cnt_reg);

        link_raddr = {cur_reg[CAP_W-1:0], lvl_reg};
        if (state_reg == slss_pkg::S_RM_CHK) begin
            link_raddr = {hit_reg[CAP_W-1:0], lvl_reg};
        end
        key_raddr  = nx_link[CAP_W-1:0];
        free_raddr = pop_pos;
        free_we    = state_reg == slss_pkg::S_RM_PUSH;
        free_waddr = free_cnt_reg[CAP_W-1:0];
        key_we     = state_reg == slss_pkg::S_POP_W;
        key_waddr  = node_w;

        link_we    = 1'b0;
        link_waddr = {pred_reg[lvl_reg][CAP_W-1:0], lvl_reg};
        link_wdata = {1'b0, node_reg};
        unique case (state_reg)
            slss_pkg::S_INS_A: begin
                link_we    = 1'b1;
                link_waddr = {node_reg, lvl_reg};
                link_wdata = succ_reg[lvl_reg];
            end
            slss_pkg::S_INS_B: link_we = !pred_head_reg[lvl_reg];
            slss_pkg::S_RM_WR: begin
                link_we    = !pred_head_reg[lvl_reg];
                link_wdata = link_rdata;
            end
            default: link_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= slss_pkg::S_IDLE;
            free_cnt_reg <= PTR_W'(CAPACITY);
            wm_reg       <= PTR_W'(CAPACITY);
            lfsr_reg     <= slss_pkg::LFSR_SEED;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= NIL;
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                slss_pkg::S_IDLE: if (in_valid) begin
                    key_reg      <= key_in;
                    op_reg       <= slss_pkg::opcode_t'(in_op);
                    cur_head_reg <= 1'b1;
                    cur_reg      <= NIL;
                    lvl_reg      <= LVL_TOP;
                end
                slss_pkg::S_LINK_W, slss_pkg::S_KEY_W: begin
                    if (lvl_end) begin
                        pred_reg[lvl_reg]      <= cur_reg;
                        pred_head_reg[lvl_reg] <= cur_head_reg;
                        succ_reg[lvl_reg]      <= end_nx;
                        if (lvl_reg == '0) begin
                            hit_reg     <= end_nx;
                            present_reg <= end_eq;
                        end else begin
                            lvl_reg <= lvl_reg - LVL_W'(1);
                        end
                    end else if (state_reg == slss_pkg::S_LINK_W) begin
                        nx_reg <= nx_link;
                    end else begin
                        cur_reg      <= nx_reg;
                        cur_head_reg <= 1'b0;
                    end
                end
                slss_pkg::S_DECIDE: begin
                    lvl_reg <= '0;
                    priority case (op_reg)
                        slss_pkg::OP_INSERT:
                            status_reg <= present_reg ? slss_pkg::ST_PRESENT
                                                      : slss_pkg::ST_FULL;
                        slss_pkg::OP_REMOVE:
                            status_reg <= present_reg ? slss_pkg::ST_REMOVED
                                                      : slss_pkg::ST_ABSENT;
                        default:
                            status_reg <= present_reg ? slss_pkg::ST_FOUND
                                                      : slss_pkg::ST_ABSENT;
                    endcase
                end
                slss_pkg::S_DRAW: begin
                    lfsr_reg <= lfsr_next;
                    if (draw_stop) begin
                        top_reg <= lvl_reg;
                    end else begin
                        lvl_reg <= lvl_reg + LVL_W'(1);
                    end
                end
                slss_pkg::S_POP: begin
                    use_init_reg <= free_cnt_reg <= wm_reg;
                    if ((free_cnt_reg - PTR_W'(1)) < wm_reg) begin
                        wm_reg <= free_cnt_reg - PTR_W'(1);
                    end
                    free_cnt_reg <= free_cnt_reg - PTR_W'(1);
                end
                slss_pkg::S_POP_W: begin
                    node_reg   <= node_w;
                    lvl_reg    <= '0;
                    status_reg <= slss_pkg::ST_INSERTED;
                end
                slss_pkg::S_INS_B: begin
                    if (pred_head_reg[lvl_reg]) begin
                        head_reg[lvl_reg] <= {1'b0, node_reg};
                    end
                    if (lvl_reg != top_reg) begin
                        lvl_reg <= lvl_reg + LVL_W'(1);
                    end
                end
                slss_pkg::S_RM_WR: begin
                    if (pred_head_reg[lvl_reg]) begin
                        head_reg[lvl_reg] <= link_rdata;
                    end
                    if (lvl_reg != LVL_TOP) begin
                        lvl_reg <= lvl_reg + LVL_W'(1);
                    end
                end
                slss_pkg::S_RM_PUSH: free_cnt_reg <= free_cnt_reg + PTR_W'(1);
                default: ;
            endcase
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= PTR_W'(CAPACITY))
        else $error("free count above capacity");

    a_mark_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        wm_reg <= free_cnt_reg)
        else $error("free stack low-water mark above free count");

    a_insert_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slss_pkg::S_DRAW) |-> (free_cnt_reg != '0))
        else $error("level drawn for insert into a full pool");

    a_remove_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slss_pkg::S_RM_CHK) |-> (present_reg && hit_reg != NIL))
        else $error("unlink started without a matching node");

endmodule

`default_nettype wire

// ----- rtl/skip_list_sorted_set_top.sv -----
// ----------------------------------------------------------------------------
// skip_list_sorted_set_top: sorted set of signed keys held as a skip list
// Holds the promotion threshold register and the result register around
// the walk-and-splice sequencer.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_*      | in        | tuser: opcode; tdata: key_value
//  m_*      | out       | tuser: status, found_flag; tdata: stored_count
//  cfg_*    | in        | promote_threshold, written when cfg_we is high
//
//  Each link followed passes through the link read, link wait and key wait
//  states; the walk is bound by the link and key memory reads. An insert
//  then draws its level one trial at a time and splices each level with a
//  successor write and a predecessor write, a remove unlinks each level
//  with a check and a write. The result register frees the core as soon as
//  it takes the result. s_tready is low while a transaction is in progress
//  or its result waits for the result register. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module skip_list_sorted_set_top #(
    parameter int MAX_LEVEL = slss_pkg::DEF_MAX_LEVEL,
    parameter int CAPACITY  = slss_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = slss_pkg::DEF_KEY_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] key_value
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [10:0] stored_count, [15:11] zero
    output logic [3:0]       m_tuser,   // [2:0] status, [3] found_flag
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);

    logic [slss_pkg::THRESH_W-1:0] thresh_reg;
    slss_pkg::result_t             res, out_reg;
    logic                          res_valid, res_ready, m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= slss_pkg::THRESH_RESET;
        end else if (cfg_we) begin
            thresh_reg <= cfg_wdata;
        end
    end

    slss_core #(
        .MAX_LEVEL(MAX_LEVEL), .CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)
    ) u_core (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tuser), .in_key(s_tdata),
        .thresh(thresh_reg),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_reg.count};
    assign m_tuser  = {out_reg.found, out_reg.status};

endmodule

`default_nettype wire

// ----- verif/tb_skip_list_sorted_set_top.sv -----
// ----------------------------------------------------------------------------
// tb_skip_list_sorted_set_top: self-checking bench for the skip-list set
// Drives insert, search and remove transactions with random gaps and stalls,
// predicts status, found flag and key count from a shadow set, and checks
// every result in order. The promotion threshold is swept between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_skip_list_sorted_set_top;

    localparam int CAP       = 1024;
    localparam int CYC_LIMIT = 20000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    skip_list_sorted_set_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Shadow of the set contents; the internal shape does not affect results.
    bit                 key_set[logic signed [31:0]];
    logic signed [31:0] held_keys[$];
    slss_pkg::result_t  pending_results[$];
    int                 fail_count = 0;
    int                 cycle_count = 0;
    bit                 hold_off;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT) begin
            $display("tb_skip_list_sorted_set_top: errors");
            $finish;
        end
    end

    function automatic slss_pkg::result_t apply_op(slss_pkg::opcode_t op,
                                                   logic signed [31:0] k);
        slss_pkg::result_t r;
        bit present;
        present = key_set.exists(k);
        r.found = present;
        case (op)
            slss_pkg::OP_INSERT: begin
                if (present) begin
                    r.status = slss_pkg::ST_PRESENT;
                end else if (key_set.num() >= CAP) begin
                    r.status = slss_pkg::ST_FULL;
                end else begin
                    key_set[k] = 1'b1;
                    held_keys.push_back(k);
                    r.status = slss_pkg::ST_INSERTED;
                end
            end
            slss_pkg::OP_REMOVE: begin
                if (present) begin
                    key_set.delete(k);
                    foreach (held_keys[i])
                        if (held_keys[i] == k) begin
                            held_keys.delete(i);
                            break;
                        end
                    r.status = slss_pkg::ST_REMOVED;
                end else begin
                    r.status = slss_pkg::ST_ABSENT;
                end
            end
            default: r.status = present ? slss_pkg::ST_FOUND : slss_pkg::ST_ABSENT;
        endcase
        r.count = slss_pkg::COUNT_W'(key_set.num());
        return r;
    endfunction

    function automatic int gap_len();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) return 0;
        if (n < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // With no gap the next transaction is driven at the same falling edge,
    // so tvalid is only dropped when a gap follows.
    task automatic send_op(slss_pkg::opcode_t op, logic signed [31:0] k);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= k;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_op(op, k));
        @(negedge aclk);
        gap = gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_threshold(logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_key();
        int n;
        n = $urandom_range(0, 9);
        if (n < 5 && held_keys.size() != 0)
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        if (n < 8)
            return $signed($urandom_range(0, 63)) - 32;
        return $urandom();
    endfunction

    task automatic test_extremes();
        send_op(slss_pkg::OP_SEARCH, 32'sh8000_0000);
        send_op(slss_pkg::OP_REMOVE, 32'sh7FFF_FFFF);
        send_op(slss_pkg::OP_INSERT, 32'sh8000_0000);
        send_op(slss_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        send_op(slss_pkg::OP_INSERT, 0);
        send_op(slss_pkg::OP_INSERT, -1);
        // A repeated insert is rejected and leaves the count alone.
        send_op(slss_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        send_op(slss_pkg::OP_SEARCH, 32'sh8000_0000);
        send_op(slss_pkg::OP_SEARCH_ALT, -1);
        send_op(slss_pkg::OP_SEARCH_ALT, 5);
        send_op(slss_pkg::OP_SEARCH, 1);
        send_op(slss_pkg::OP_REMOVE, 0);
        send_op(slss_pkg::OP_REMOVE, 0);
        send_op(slss_pkg::OP_REMOVE, 32'sh8000_0000);
        send_op(slss_pkg::OP_SEARCH, 32'sh8000_0000);
        send_op(slss_pkg::OP_INSERT, 32'sh5555_5555);
        send_op(slss_pkg::OP_INSERT, 32'shAAAA_AAAA);
    endtask

    task automatic test_random_mix(int count);
        int n;
        slss_pkg::opcode_t op;
        repeat (count) begin
            n = $urandom_range(0, 9);
            op = (n < 5) ? slss_pkg::OP_INSERT :
                 (n < 7) ? slss_pkg::OP_REMOVE :
                 (n < 9) ? slss_pkg::OP_SEARCH : slss_pkg::OP_SEARCH_ALT;
            send_op(op, pick_key());
        end
    endtask

    // Fills the pool with distinct keys, probes the full case, then frees part of it.
    task automatic test_full_pool();
        int base;
        int idx;
        base = $urandom_range(0, 1000) * 4096;
        idx = 0;
        while (key_set.num() < CAP) begin
            send_op(slss_pkg::OP_INSERT, base + idx * 3 - 4000);
            idx++;
        end
        send_op(slss_pkg::OP_INSERT, 32'sh7FFF_FFF0);
        send_op(slss_pkg::OP_INSERT, held_keys[0]);
        send_op(slss_pkg::OP_SEARCH, held_keys[CAP - 1]);
        repeat (40)
            send_op(slss_pkg::OP_REMOVE, held_keys[$urandom_range(0, held_keys.size() - 1)]);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            test_random_mix(10);
        join
    endtask

    // Result side: random stalls, long stalls on request, in-order checking.
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            n = $urandom_range(0, 99);
            if (hold_off) m_tready <= 1'b0;
            else if (n < 3) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(10, 50)) @(negedge aclk);
                m_tready <= 1'b1;
            end else m_tready <= (n < 70);
        end
    end

    always @(posedge aclk) begin
        slss_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[2:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[2:0]);
                    fail_count++;
                end
                if (m_tuser[3] !== want.found) begin
                    $error("found_flag: expected %0d, got %0d", want.found, m_tuser[3]);
                    fail_count++;
                end
                if (m_tdata[10:0] !== want.count) begin
                    $error("stored_count: expected %0d, got %0d", want.count, m_tdata[10:0]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        hold_off = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = slss_pkg::OP_SEARCH;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_extremes();
        test_backpressure();
        test_random_mix(60);
        write_threshold(8'd0);
        test_random_mix(40);
        write_threshold(8'd255);
        test_random_mix(40);
        write_threshold(8'd64);
        test_full_pool();
        write_threshold(8'd200);
        test_random_mix(60);
        drain();

        if (fail_count == 0)
            $display("tb_skip_list_sorted_set_top: clean");
        else
            $display("tb_skip_list_sorted_set_top: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- skip_list_sorted_set_top.f -----
rtl/slss_pkg.sv
rtl/slss_ram.sv
rtl/slss_core.sv
rtl/skip_list_sorted_set_top.sv
verif/tb_skip_list_sorted_set_top.sv
